// ===== hw/rtl/msps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msps_pkg
// Shared types, codes and helpers of the multi-servo pulse sequencer.
// ----------------------------------------------------------------------------
package msps_pkg;

  localparam int CH_W     = 3;
  localparam int US_W     = 12;
  localparam int TICK_W   = 7;
  localparam int PRE_W    = 6;
  localparam int MAX_CHANNELS = 1 << CH_W;

  localparam logic [US_W-1:0]   STARTUP_DELAY_US = 12'd100;
  localparam logic [TICK_W-1:0] TICKS_PER_US_RST = 7'd16;
  localparam logic [US_W-1:0]   SLOT_US_RST      = 12'd2500;

  // input word opcodes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // configuration register indexes
  localparam logic REG_TICKS_PER_US = 1'b0;
  localparam logic REG_SLOT_US      = 1'b1;

  typedef struct packed {
    logic            pending;
    logic [CH_W-1:0] ch;
    logic [US_W-1:0] pos;
  } tb_state_t;

  function automatic logic [TICK_W-1:0] eff_ticks(input logic [TICK_W-1:0] tpu);
    logic [TICK_W-1:0] t;
    begin
      t = tpu;
      if (tpu == '0) t = 7'd1;
      else if (tpu > 7'd64) t = 7'd64;
      return t;
    end
  endfunction

  function automatic logic [US_W-1:0] eff_slot(input logic [US_W-1:0] slot);
    return (slot < 12'd2) ? 12'd2 : slot;
  endfunction

  // limit a width so the pin falls inside its slot
  function automatic logic [US_W-1:0] clamp_width(input logic [US_W-1:0] w,
                                                 input logic [US_W-1:0] slot);
    logic [US_W-1:0] lim;
    begin
      lim = eff_slot(slot) - 12'd1;
      return (w > lim) ? lim : w;
    end
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/msps_timebase.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msps_timebase
// Prescaler, slot position, active channel and startup delay counters.
// ----------------------------------------------------------------------------
module msps_timebase import msps_pkg::*; #(
  parameter int NUM_CHANNELS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire logic              tick,
  input  wire logic [TICK_W-1:0] ticks_per_us,
  input  wire logic [US_W-1:0]   slot_us,
  output tb_state_t              state_next
);

  logic [PRE_W-1:0] prescale, prescale_next;
  tb_state_t        state;
  logic [PRE_W-1:0] pc_inc;
  logic             us_done;
  logic [US_W-1:0]  pos_inc;
  logic [CH_W:0]    ch_inc;

  always_comb begin
    pc_inc        = prescale + 6'd1;
    us_done       = ({1'b0, pc_inc} >= eff_ticks(ticks_per_us)) || (pc_inc == '0);
    pos_inc       = state.pos + 12'd1;
    ch_inc        = {1'b0, state.ch} + 4'd1;
    prescale_next = prescale;
    state_next    = state;
    if (tick) begin
      prescale_next = us_done ? '0 : pc_inc;
      if (us_done) begin
        if (state.pending) begin
          if (pos_inc >= STARTUP_DELAY_US) begin
            state_next = '{pending: 1'b0, ch: '0, pos: '0};
          end else begin
            state_next.pos = pos_inc;
          end
        end else if (pos_inc >= eff_slot(slot_us) || pos_inc == '0) begin
          state_next.pos = '0;
          state_next.ch  = (ch_inc >= (CH_W+1)'(NUM_CHANNELS)) ? '0 : ch_inc[CH_W-1:0];
        end else begin
          state_next.pos = pos_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale <= '0;
      state    <= '{pending: 1'b1, ch: '0, pos: '0};
    end else if (advance) begin
      prescale <= prescale_next;
      state    <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/msps_width_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msps_width_mem
// Pulse width store: registered read, write-through forwarding, and valid
// bits so unwritten entries read as their power-on width.
// ----------------------------------------------------------------------------
module msps_width_mem import msps_pkg::*; #(
  parameter int NUM_CHANNELS = 8,
  parameter int WIDTH_MID_US = 1500,
  parameter int WIDTH_MIN_US = 1000,
  parameter int WIDTH_MAX_US = 2000
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            rd_en,
  input  wire logic [CH_W-1:0] rd_addr,
  input  wire logic            wr_en,
  input  wire logic [CH_W-1:0] wr_addr,
  input  wire logic [US_W-1:0] wr_data,
  output logic      [US_W-1:0] rd_data
);

  logic [US_W-1:0]         mem [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] vld;
  logic [US_W-1:0]         mem_q;
  logic [US_W-1:0]         fwd_data_q;
  logic                    fwd_q;
  logic                    vld_q;
  logic [CH_W-1:0]         addr_q;

  function automatic logic [US_W-1:0] reset_width(input logic [CH_W-1:0] ch);
    logic [US_W-1:0] w;
    begin
      w = US_W'(WIDTH_MID_US);
      if (NUM_CHANNELS > 2 && ch == 3'd2) w = US_W'(WIDTH_MIN_US);
      if ({1'b0, ch} == (CH_W+1)'(NUM_CHANNELS - 1)) w = US_W'(WIDTH_MAX_US);
      return w;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q      <= mem[rd_addr];
      vld_q      <= vld[rd_addr];
      fwd_q      <= wr_en && (wr_addr == rd_addr);
      fwd_data_q <= wr_data;
      addr_q     <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // take a same-cycle write first, then the stored word, else the default
  always_comb begin
    if (fwd_q)      rd_data = fwd_data_q;
    else if (vld_q) rd_data = mem_q;
    else            rd_data = reset_width(addr_q);
  end

endmodule
`default_nettype wire

// ===== hw/rtl/multi_servo_pulse_sequencer_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// multi_servo_pulse_sequencer_unit
// Time-slotted servo pulse generator for up to eight channels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): each word is either one timer tick
//   (opcode OP_TICK) or a pulse width write (OP_WRITE, channel, width_us).
//   Every input word yields exactly one output word (pins, active_channel)
//   on the out_valid/out_ready channel, showing pin levels after that word.
//   Config channel (cfg_valid/cfg_ready, always ready): index 0 sets
//   ticks_per_us, index 1 sets slot_us. Write it only while the unit is idle.
// Timing:
//   One word accepted per cycle while the output is taken. On acceptance the
//   counters update and the width store is read into the stage 1 registers;
//   when the output register is free, it registers the pin compare. Width
//   store reads are registered; a write to the channel being read in the same
//   cycle is forwarded, so back-to-back words never stall on the width store.
// Reset:
//   Synchronous rst restores register defaults, puts all widths at their
//   power-on values (valid bits, no clearing pass) and starts the 100 us
//   startup delay with all pins low before channel 0's first slot.
// Stall:
//   With out_ready low the output and one internal stage fill, then in_ready
//   drops until the receiver takes a word.
// ----------------------------------------------------------------------------
module multi_servo_pulse_sequencer_unit import msps_pkg::*; #(
  parameter int NUM_CHANNELS = 8,
  parameter int WIDTH_MID_US = 1500,
  parameter int WIDTH_MIN_US = 1000,
  parameter int WIDTH_MAX_US = 2000
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic            opcode,
  input  wire logic [CH_W-1:0] channel,
  input  wire logic [US_W-1:0] width_us,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [MAX_CHANNELS-1:0] pins,
  output logic [CH_W-1:0]      active_channel,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic            cfg_index,
  input  wire logic [US_W-1:0] cfg_data
);

  logic [TICK_W-1:0] ticks_per_us;
  logic [US_W-1:0]   slot_us;

  logic              accept;
  logic              wr_en;
  logic [US_W-1:0]   wr_width;
  tb_state_t         tb_next;

  logic              s1_valid;
  tb_state_t         s1_state;
  logic [US_W-1:0]   s1_width;
  logic [US_W-1:0]   s1_limit;
  logic [MAX_CHANNELS-1:0] s1_pins;
  logic              out_load;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_us <= TICKS_PER_US_RST;
      slot_us      <= SLOT_US_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TICKS_PER_US: ticks_per_us <= cfg_data[TICK_W-1:0];
        REG_SLOT_US:      slot_us      <= cfg_data;
        default:          ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow
  // stage 1 moves to the output register whenever that register is free
  assign out_load = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || out_load;
  assign accept   = in_valid && in_ready;

  // drop writes to channels beyond the configured count; clamp the rest
  assign wr_en    = accept && (opcode == OP_WRITE)
                    && ({1'b0, channel} < (CH_W+1)'(NUM_CHANNELS));
  assign wr_width = clamp_width(width_us, slot_us);

  // ---------------------------------------------------------------- stage 0
  msps_timebase #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_timebase (
    .clk          (clk),
    .rst          (rst),
    .advance      (accept),
    .tick         (opcode == OP_TICK),
    .ticks_per_us (ticks_per_us),
    .slot_us      (slot_us),
    .state_next   (tb_next)
  );

  // read the width of the channel active after this word
  msps_width_mem #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .WIDTH_MID_US (WIDTH_MID_US),
    .WIDTH_MIN_US (WIDTH_MIN_US),
    .WIDTH_MAX_US (WIDTH_MAX_US)
  ) u_width_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (tb_next.ch),
    .wr_en   (wr_en),
    .wr_addr (channel),
    .wr_data (wr_width),
    .rd_data (s1_width)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_state <= tb_next;
    end
  end

  // ---------------------------------------------------------------- stage 1
  // outside the startup delay, hold the pin high while the slot position is below the clamped width
  always_comb begin
    s1_limit = clamp_width(s1_width, slot_us);
    s1_pins  = '0;
    if (!s1_state.pending && s1_state.pos < s1_limit) begin
      s1_pins = MAX_CHANNELS'(1) << s1_state.ch;
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pins           <= s1_pins;
      active_channel <= s1_state.ch;
    end
  end

  // ---------------------------------------------------------------- checks
  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted word did not reach stage 1");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while both stages are held");

  a_startup_bound: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_state.pending) |-> (s1_state.pos < STARTUP_DELAY_US))
    else $error("startup delay overran");

  a_channel_bound: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> ({1'b0, s1_state.ch} < (CH_W+1)'(NUM_CHANNELS)))
    else $error("active channel beyond channel count");

  a_one_pin: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> $onehot0(s1_pins))
    else $error("more than one pin driven high");

endmodule
`default_nettype wire

// ===== test/multi_servo_pulse_sequencer_checker.sv =====
// ----------------------------------------------------------------------------
// multi_servo_pulse_sequencer_checker
// Watches the input, output and register channels of the servo sequencer,
// keeps its own timing and width state, and compares every output word in
// order against the predicted pin levels and active channel.
// ----------------------------------------------------------------------------
module multi_servo_pulse_sequencer_checker import msps_pkg::*; #(
  parameter int NUM_CHANNELS = 8,
  parameter int WIDTH_MID_US = 1500,
  parameter int WIDTH_MIN_US = 1000,
  parameter int WIDTH_MAX_US = 2000
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  input  wire logic                    in_ready,
  input  wire logic                    opcode,
  input  wire logic [CH_W-1:0]         channel,
  input  wire logic [US_W-1:0]         width_us,
  input  wire logic                    out_valid,
  input  wire logic                    out_ready,
  input  wire logic [MAX_CHANNELS-1:0] pins,
  input  wire logic [CH_W-1:0]         active_channel,
  input  wire logic                    cfg_valid,
  input  wire logic                    cfg_ready,
  input  wire logic                    cfg_index,
  input  wire logic [US_W-1:0]         cfg_data,
  output int                           mismatches,
  output int                           outstanding
);

  typedef struct packed {
    logic [MAX_CHANNELS-1:0] pins;
    logic [CH_W-1:0]         ch;
  } servo_word_t;

  servo_word_t       expected_levels_q[$];
  logic [TICK_W-1:0] tick_reg;
  logic [US_W-1:0]   slot_reg;
  logic [PRE_W-1:0]  tick_count;
  logic [US_W-1:0]   slot_pos;
  logic [CH_W-1:0]   serving_ch;
  logic              in_startup;
  logic [US_W-1:0]   width_mem [MAX_CHANNELS];

  function automatic int ticks_eff();
    int t;
    t = int'(tick_reg);
    if (t < 1) t = 1;
    if (t > 64) t = 64;
    return t;
  endfunction

  function automatic int slot_eff();
    return (int'(slot_reg) < 2) ? 2 : int'(slot_reg);
  endfunction

  function automatic void step_microsecond();
    slot_pos = slot_pos + 1'b1;
    if (in_startup) begin
      if (slot_pos >= STARTUP_DELAY_US) begin
        in_startup = 1'b0;
        slot_pos   = '0;
        serving_ch = '0;
      end
    end else if (int'(slot_pos) >= slot_eff() || slot_pos == '0) begin
      slot_pos   = '0;
      serving_ch = (int'(serving_ch) >= NUM_CHANNELS - 1) ? '0 : serving_ch + 1'b1;
    end
  endfunction

  function automatic servo_word_t pin_view();
    servo_word_t v;
    int          lim;
    int          w;
    v.ch   = serving_ch;
    v.pins = '0;
    if (!in_startup) begin
      w   = int'(width_mem[serving_ch]);
      lim = slot_eff() - 1;
      if (w > lim) w = lim;
      if (int'(slot_pos) < w) v.pins[serving_ch] = 1'b1;
    end
    return v;
  endfunction

  // advance the model by one input word and return the levels it leaves
  function automatic servo_word_t apply_word(input logic            op,
                                             input logic [CH_W-1:0] ch,
                                             input logic [US_W-1:0] w);
    int lim;
    if (op == OP_WRITE) begin
      lim = slot_eff() - 1;
      if (int'(w) > lim) w = lim[US_W-1:0];
      if (int'(ch) < NUM_CHANNELS) width_mem[ch] = w;
    end else begin
      tick_count = tick_count + 1'b1;
      if (int'(tick_count) >= ticks_eff() || tick_count == '0) begin
        tick_count = '0;
        step_microsecond();
      end
    end
    return pin_view();
  endfunction

  always @(posedge clk) begin : watch
    servo_word_t got;
    servo_word_t want;
    if (rst) begin
      tick_reg   = TICKS_PER_US_RST;
      slot_reg   = SLOT_US_RST;
      tick_count = '0;
      slot_pos   = '0;
      serving_ch = '0;
      in_startup = 1'b1;
      for (int i = 0; i < MAX_CHANNELS; i++) width_mem[i] = US_W'(WIDTH_MID_US);
      if (NUM_CHANNELS > 2) width_mem[2] = US_W'(WIDTH_MIN_US);
      width_mem[NUM_CHANNELS-1] = US_W'(WIDTH_MAX_US);
      expected_levels_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_TICKS_PER_US) tick_reg = cfg_data[TICK_W-1:0];
        else slot_reg = cfg_data;
      end
      // compare before pushing: an output word never stems from this edge's input
      if (out_valid && out_ready) begin
        got.pins = pins;
        got.ch   = active_channel;
        if (expected_levels_q.size() == 0) begin
          mismatches++;
          $display("%0t: output word with none expected, actual pins %b channel %0d",
                   $time, got.pins, got.ch);
        end else begin
          want = expected_levels_q.pop_front();
          if (got.pins !== want.pins) begin
            mismatches++;
            $display("%0t: pins expected %b actual %b", $time, want.pins, got.pins);
          end
          if (got.ch !== want.ch) begin
            mismatches++;
            $display("%0t: active_channel expected %0d actual %0d", $time, want.ch, got.ch);
          end
        end
      end
      if (in_valid && in_ready) expected_levels_q.push_back(apply_word(opcode, channel, width_us));
    end
    outstanding = expected_levels_q.size();
  end

endmodule

// ===== test/multi_servo_pulse_sequencer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// multi_servo_pulse_sequencer_unit_tb
// Drives tick and width words through the servo sequencer under a series of
// tick-rate and slot-length settings, with random gaps on both channels; a
// checker beside the unit predicts and compares every output word.
// ----------------------------------------------------------------------------
module multi_servo_pulse_sequencer_unit_tb;
  import msps_pkg::*;

  localparam int N_CH        = 8;
  localparam int MID_US      = 1500;
  localparam int MIN_US      = 1000;
  localparam int MAX_US      = 2000;
  localparam int QUIET_LIMIT = 1000;
  localparam int N_PHASES    = 8;

  // Timing settings per random phase: raw register data, then word count.
  // Zero rates and slots, out-of-range rates, masked upper bits and a slot
  // shrinking under a running count all show up in this order.
  localparam int PH_TICKS [N_PHASES] = '{0, 127, 'hF81, 3, 64, 2, 1, 1};
  localparam int PH_SLOT  [N_PHASES] = '{0, 4095, 5, 12, 3, 1, 2, 9};
  localparam int PH_WORDS [N_PHASES] = '{200, 120, 260, 260, 150, 200, 260, 300};

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    in_valid  = 1'b0;
  logic                    opcode    = OP_TICK;
  logic [CH_W-1:0]         channel   = '0;
  logic [US_W-1:0]         width_us  = '0;
  logic                    out_ready = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_index = REG_TICKS_PER_US;
  logic [US_W-1:0]         cfg_data  = '0;
  logic                    in_ready;
  logic                    out_valid;
  logic                    cfg_ready;
  logic [MAX_CHANNELS-1:0] pins;
  logic [CH_W-1:0]         active_channel;

  int mismatches;
  int outstanding;
  int tx_idle_pct  = 35;
  int rx_idle_pct  = 62;
  int quiet_cycles = 0;
  int slot_now     = 2500;
  int words_sent   = 0;

  always #5 clk = ~clk;

  multi_servo_pulse_sequencer_unit #(
    .NUM_CHANNELS (N_CH),
    .WIDTH_MID_US (MID_US),
    .WIDTH_MIN_US (MIN_US),
    .WIDTH_MAX_US (MAX_US)
  ) u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .channel        (channel),
    .width_us       (width_us),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pins           (pins),
    .active_channel (active_channel),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  multi_servo_pulse_sequencer_checker #(
    .NUM_CHANNELS (N_CH),
    .WIDTH_MID_US (MID_US),
    .WIDTH_MIN_US (MIN_US),
    .WIDTH_MAX_US (MAX_US)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .channel        (channel),
    .width_us       (width_us),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pins           (pins),
    .active_channel (active_channel),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  // Stall the receiver at random; the rate follows the current idling regime.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Drop the run if no word moves on any channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offer one input word and hold it until accepted. Valid is left high so
  // the next call can keep it up without a drop in between.
  task automatic send_word(input logic op, input logic [CH_W-1:0] ch,
                           input logic [US_W-1:0] w);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    channel  <= ch;
    width_us <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Write both timing registers back to back; call only while the unit is idle.
  task automatic program_timing(input logic [US_W-1:0] ticks, input logic [US_W-1:0] slot);
    cfg_valid <= 1'b1;
    cfg_index <= REG_TICKS_PER_US;
    cfg_data  <= ticks;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_SLOT_US;
    cfg_data  <= slot;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    slot_now = (int'(slot) < 2) ? 2 : int'(slot);
  endtask

  // Stop offering words, wait for every predicted word to come out, then let
  // the two-stage pipeline settle before returning on a rising edge.
  task automatic drain_unit();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (3) @(negedge clk);
    @(posedge clk);
  endtask

  // Widths lean on zero and the clamp edge of the current slot, with some
  // full-range values so every bit toggles.
  function automatic logic [US_W-1:0] pick_width();
    int w;
    case ($urandom_range(9))
      0, 1: begin
        w = 0;
      end
      2: begin
        w = slot_now - 1;
      end
      3: begin
        w = slot_now;
      end
      4, 5: begin
        w = int'($urandom_range(4095));
      end
      6: begin
        w = 4095;
      end
      default: begin
        w = int'($urandom_range(slot_now));
      end
    endcase
    return w[US_W-1:0];
  endfunction

  // One random word: mostly ticks to move time, writes mixed in. Advance the
  // idling regime as the word count grows.
  task automatic send_random_word();
    logic            op;
    logic [CH_W-1:0] ch;
    logic [US_W-1:0] w;
    op = ($urandom_range(99) < 30) ? OP_WRITE : OP_TICK;
    ch = CH_W'($urandom_range(MAX_CHANNELS - 1));
    w  = pick_width();
    send_word(op, ch, w);
    words_sent++;
    if (words_sent == 600) begin
      tx_idle_pct = 62;
      rx_idle_pct = 35;
    end else if (words_sent == 1200) begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed words under reset timing, all inside the startup delay: field
    // extremes, widths over the slot limit, width zero, alternating bits.
    send_word(OP_TICK,  3'd7, 12'hFFF);
    send_word(OP_WRITE, 3'd0, 12'd0);
    send_word(OP_WRITE, 3'd7, 12'hFFF);
    send_word(OP_WRITE, 3'd1, 12'd2499);
    send_word(OP_WRITE, 3'd4, 12'd2500);
    send_word(OP_WRITE, 3'd2, 12'd1);
    send_word(OP_TICK,  3'd0, 12'h000);
    send_word(OP_TICK,  3'd5, 12'hAAA);
    send_word(OP_WRITE, 3'd3, 12'hAAA);
    send_word(OP_WRITE, 3'd5, 12'h555);
    send_word(OP_TICK,  3'd2, 12'h555);
    send_word(OP_WRITE, 3'd6, 12'd1);
    drain_unit();

    // Random phases, each under its own timing, with the unit drained between
    // them so register writes never land on a word in flight.
    for (int p = 0; p < N_PHASES; p++) begin
      program_timing(US_W'(PH_TICKS[p]), US_W'(PH_SLOT[p]));
      for (int k = 0; k < PH_WORDS[p]; k++) send_random_word();
      drain_unit();
    end

    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/msps_pkg.sv
hw/rtl/msps_timebase.sv
hw/rtl/msps_width_mem.sv
hw/rtl/multi_servo_pulse_sequencer_unit.sv
test/multi_servo_pulse_sequencer_checker.sv
test/multi_servo_pulse_sequencer_unit_tb.sv
